>>> design/imhd_pkg.sv
// ----------------------------------------------------------------------------
// imhd_pkg
// Request and response types, operation and status codes of the indexed heap.
// ----------------------------------------------------------------------------
`default_nettype none
package imhd_pkg;
   localparam int KEY_BITS = 10;
   localparam int NUM_KEYS = 1024;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DECR   = 2'd1,
      FUNC_POP    = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_FULL   = 3'd2,
      ST_DUP    = 3'd3,
      ST_ABSENT = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  entry_key;
      logic [15:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [9:0]  out_key;
      logic [15:0] out_value;
      logic [2:0]  status;
      logic [10:0] occupancy;
   } rsp_type;
endpackage
`default_nettype wire

>>> design/indexed_min_heap_decrement.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_decrement
// Indexed binary min-heap with insert, conditional decrement and pop.
// ----------------------------------------------------------------------------
// One request in on req_ (valid/ready), one response out on rsp_ per request.
// Requests are handled one at a time. Heap slots live in one single-port
// synchronous RAM, the key-to-slot map in a second, both with a registered read.
// Sift up per level: read parent, compare and move it down; sift down per
// level: read left, read right, compare and move child up.
// A no-op or a pop on empty goes straight to the response; a rejected insert
// or absent key stops after the map read, a decrement with no change after
// the slot read; an insert or decrement then sifts up, and a pop reads the root
// and, if others remain, the last slot, then sifts down.
// The machine returns to idle after each request, so a request is taken only
// once the previous one has reached its response.
// After reset the block sweeps the position map, one key a cycle, marking all
// keys absent; req_ready stays low until the sweep is done.
// A response is held in a register until taken; meanwhile the next request
// is taken and processed, then waits with req_ready low until that register
// is free.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap_decrement #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire imhd_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output imhd_pkg::rsp_type     rsp_data
);
   localparam int PB = $clog2(CAPACITY);
   localparam int CB = $clog2(CAPACITY + 1);
   localparam int XB = PB + 2;
   localparam int KB = imhd_pkg::KEY_BITS;
   localparam int SW = KB + VALUE_BITS;
   localparam int MW = 1 + PB;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_MAPCHK, S_SLOTCHK,
      S_UPRD, S_UPCMP,
      S_POPROOT, S_POPLAST,
      S_DNRDL, S_DNRDR, S_DNCMP,
      S_FIN, S_DONE
   } state_type;

   logic [SW-1:0] heap_mem [CAPACITY];
   logic [MW-1:0] map_mem  [imhd_pkg::NUM_KEYS];

   logic [PB-1:0] h_addr;
   logic          h_we;
   logic [SW-1:0] h_wd, h_rd;
   logic [KB-1:0] m_addr;
   logic          m_we;
   logic [MW-1:0] m_wd, m_rd;

   state_type             state_ff;
   logic [KB-1:0]         clr_ff;
   logic [CB-1:0]         cnt_ff;
   imhd_pkg::req_type     req_ff;
   imhd_pkg::rsp_type     rsp_ff;
   logic                  rspv_ff;
   logic                  rspv_in;
   imhd_pkg::status_type  st_ff;
   logic [PB-1:0]         i_ff;
   logic [KB-1:0]         ck_ff, lk_ff, okey_ff;
   logic [VALUE_BITS-1:0] cv_ff, lv_ff, oval_ff;

   logic [VALUE_BITS-1:0] rv, hv, sel_v;
   logic [KB-1:0]         hk, sel_k;
   logic [PB-1:0]         pa;
   logic [PB:0]           lc, rc;
   logic                  up_move, r_ok, use_r, dn_move, load_rsp;

   always_ff @(posedge clock) begin
      if (h_we) heap_mem[h_addr] <= h_wd;
      h_rd <= heap_mem[h_addr];
   end
   always_ff @(posedge clock) begin
      if (m_we) map_mem[m_addr] <= m_wd;
      m_rd <= map_mem[m_addr];
   end

   assign rv = VALUE_BITS'(req_ff.entry_value);
   assign hk = h_rd[SW-1:VALUE_BITS];
   assign hv = h_rd[VALUE_BITS-1:0];

   assign pa = (i_ff - 1'b1) >> 1;
   assign lc = {i_ff, 1'b1};
   assign rc = lc + 1'b1;

   assign up_move = hv > cv_ff;
   assign r_ok    = XB'(rc) < XB'(cnt_ff);
   assign use_r   = r_ok && (hv < lv_ff);
   assign sel_k   = use_r ? hk : lk_ff;
   assign sel_v   = use_r ? hv : lv_ff;
   assign dn_move = sel_v < cv_ff;

   assign load_rsp = (state_ff == S_DONE) && (!rspv_ff || rsp_ready);
   assign rspv_in  = load_rsp || (rspv_ff && !rsp_ready);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   // memory port drive
   always_comb begin
      h_addr = '0; h_we = 1'b0; h_wd = {ck_ff, cv_ff};
      m_addr = ck_ff; m_we = 1'b0; m_wd = {1'b1, i_ff};
      unique case (state_ff)
         S_CLEAR: begin m_addr = clr_ff; m_we = 1'b1; m_wd = '0; end
         S_IDLE:   m_addr = req_data.entry_key;
         S_MAPCHK: h_addr = m_rd[PB-1:0];
         S_UPRD:   h_addr = pa;
         S_UPCMP: begin
            h_addr = i_ff; h_we = up_move; h_wd = h_rd;
            m_addr = hk; m_we = up_move;
         end
         S_POPROOT: begin
            h_addr = PB'(cnt_ff - 1'b1);
            m_addr = hk; m_we = 1'b1; m_wd = '0;
         end
         S_DNRDL: h_addr = lc[PB-1:0];
         S_DNRDR: h_addr = rc[PB-1:0];
         S_DNCMP: begin
            h_addr = i_ff; h_we = dn_move; h_wd = {sel_k, sel_v};
            m_addr = sel_k; m_we = dn_move;
         end
         S_FIN: begin
            h_addr = i_ff; h_we = 1'b1;
            m_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         rspv_ff  <= 1'b0;
      end else begin
         rspv_ff <= rspv_in;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == KB'(imhd_pkg::NUM_KEYS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req_valid && req_ready) begin
               req_ff  <= req_data;
               okey_ff <= '0;
               oval_ff <= '0;
               unique case (req_data.func)
                  imhd_pkg::FUNC_INSERT, imhd_pkg::FUNC_DECR: begin
                     st_ff <= imhd_pkg::ST_OK;
                     state_ff <= S_MAPCHK;
                  end
                  imhd_pkg::FUNC_POP: begin
                     if (cnt_ff == '0) begin
                        st_ff <= imhd_pkg::ST_EMPTY;
                        state_ff <= S_DONE;
                     end else begin
                        st_ff <= imhd_pkg::ST_OK;
                        state_ff <= S_POPROOT;
                     end
                  end
                  imhd_pkg::FUNC_NOP: begin
                     st_ff <= imhd_pkg::ST_OK;
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_MAPCHK: begin
               ck_ff <= req_ff.entry_key;
               if (req_ff.func == imhd_pkg::FUNC_INSERT) begin
                  if (m_rd[MW-1]) begin
                     st_ff <= imhd_pkg::ST_DUP; state_ff <= S_DONE;
                  end else if (cnt_ff >= CB'(CAPACITY)) begin
                     st_ff <= imhd_pkg::ST_FULL; state_ff <= S_DONE;
                  end else begin
                     i_ff <= PB'(cnt_ff);
                     cv_ff <= rv;
                     cnt_ff <= cnt_ff + 1'b1;
                     state_ff <= (cnt_ff == '0) ? S_FIN : S_UPRD;
                  end
               end else if (!m_rd[MW-1]) begin
                  st_ff <= imhd_pkg::ST_ABSENT; state_ff <= S_DONE;
               end else begin
                  i_ff <= m_rd[PB-1:0];
                  state_ff <= (XB'(m_rd[PB-1:0]) < XB'(cnt_ff)) ? S_SLOTCHK : S_DONE;
               end
            end
            S_SLOTCHK: begin
               if (rv < hv) begin
                  cv_ff <= hv - 1'b1;
                  state_ff <= (i_ff == '0) ? S_FIN : S_UPRD;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_UPRD: state_ff <= S_UPCMP;
            S_UPCMP: begin
               if (up_move) begin
                  i_ff <= pa;
                  state_ff <= (pa == '0) ? S_FIN : S_UPRD;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_POPROOT: begin
               okey_ff <= hk;
               oval_ff <= hv;
               cnt_ff <= cnt_ff - 1'b1;
               state_ff <= (cnt_ff == CB'(1)) ? S_DONE : S_POPLAST;
            end
            S_POPLAST: begin
               ck_ff <= hk;
               cv_ff <= hv;
               i_ff <= '0;
               state_ff <= S_DNRDL;
            end
            S_DNRDL: state_ff <= (XB'(lc) >= XB'(cnt_ff)) ? S_FIN : S_DNRDR;
            S_DNRDR: begin
               lk_ff <= hk;
               lv_ff <= hv;
               state_ff <= S_DNCMP;
            end
            S_DNCMP: begin
               if (dn_move) begin
                  i_ff <= use_r ? rc[PB-1:0] : lc[PB-1:0];
                  state_ff <= S_DNRDL;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: state_ff <= S_DONE;
            S_DONE: if (load_rsp) begin
               rsp_ff.out_key   <= okey_ff;
               rsp_ff.out_value <= 16'(oval_ff);
               rsp_ff.status    <= st_ff;
               rsp_ff.occupancy <= 11'(cnt_ff);
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
